/* rtl/mdac_pkg.sv */
// mdac_pkg: shared constants, codes and transaction types for the
// multidimensional array address calculator; no dependencies
package mdac_pkg;

   // table geometry, both must be powers of two
   localparam int NUM_ARRAYS = 16;
   localparam int MAX_DIMS   = 8;

   localparam int ID_W       = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
   localparam int SLOT_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int DIM_ADDR_W = ID_W + SLOT_W;
   localparam int DIM_DEPTH  = NUM_ARRAYS * MAX_DIMS;

   // command codes
   typedef enum logic [1:0] {
      CMD_DECLARE = 2'd0,
      CMD_BOUNDS  = 2'd1,
      CMD_INDEX   = 2'd2
   } cmd_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_SCALE,
      ST_OUT
   } state_type;

   // request transaction
   typedef struct packed {
      logic [1:0]         command;
      logic [3:0]         array_id;
      logic [30:0]        base_address;
      logic [15:0]        element_size;
      logic [3:0]         dim_count;
      logic [2:0]         dim_slot;
      logic signed [15:0] lower_bound;
      logic signed [15:0] upper_bound;
      logic signed [15:0] subscript;
      logic               last_subscript;
   } req_type;

   // response transaction
   typedef struct packed {
      logic signed [31:0] address;
      logic [3:0]         ref_array;
   } rsp_type;

   // per-dimension table entry
   typedef struct packed {
      logic [15:0] low;
      logic [16:0] extent;
   } dim_entry_type;

   // per-array descriptor entry
   typedef struct packed {
      logic [30:0] base;
      logic [15:0] size;
   } desc_entry_type;

   // sequencer controls for the arithmetic unit
   typedef struct packed {
      logic mul_scale;   // multiply by element size instead of extent
      logic prod_load;
      logic acc_load;
      logic acc_clear;
      logic rsp_load;
   } ctrl_type;

endpackage

/* rtl/mdac_ram.sv */
// mdac_ram: generic single write port, single read port RAM with
// registered read data; no dependencies
module mdac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mdac_seq.sv */
// mdac_seq: sequencer for one subscript transaction through the shared
// multiplier; depends on mdac_pkg
module mdac_seq
   import mdac_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     index_start,
   input  logic     last,
   output logic     busy,
   output ctrl_type ctrl
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and controls
   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (index_start) begin
               state_in = ST_MUL;
            end
         end
         // acc times extent, table data valid now
         ST_MUL: begin
            ctrl.prod_load = 1'b1;
            state_in       = ST_ACC;
         end
         // acc = product + (subscript - low)
         ST_ACC: begin
            ctrl.acc_load = 1'b1;
            state_in      = last ? ST_SCALE : ST_IDLE;
         end
         // element size times offset
         ST_SCALE: begin
            ctrl.mul_scale = 1'b1;
            ctrl.prod_load = 1'b1;
            state_in       = ST_OUT;
         end
         // add base, register response, restart reference
         ST_OUT: begin
            ctrl.rsp_load  = 1'b1;
            ctrl.acc_clear = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/mdac_mac.sv */
// mdac_mac: shared multiplier with product register and running offset
// accumulator; depends on mdac_pkg
module mdac_mac
   import mdac_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctrl_type           ctrl,
   input  dim_entry_type      dim,
   input  desc_entry_type     desc,
   input  logic signed [15:0] subscript,
   output logic [31:0]        address
);

   logic [31:0] acc_ff;
   logic [31:0] acc_in;
   logic [31:0] prod_ff;
   logic [31:0] prod_in;
   logic [31:0] diff_ff;
   logic [31:0] diff_in;
   logic [16:0] mul_b;

   // shared multiplier, operand a is always the running offset
   always_comb begin
      mul_b   = ctrl.mul_scale ? {1'b0, desc.size} : dim.extent;
      prod_in = acc_ff * 32'(mul_b);
   end

   // subscript minus low bound, both sign extended, wraps mod 2^32
   assign diff_in = 32'(subscript) - 32'($signed(dim.low));

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      if (ctrl.prod_load) begin
         prod_ff <= prod_in;
      end
   end

   // running row-major offset
   always_comb begin
      acc_in = acc_ff;
      priority if (ctrl.acc_clear) begin
         acc_in = '0;
      end else if (ctrl.acc_load) begin
         acc_in = prod_ff + diff_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign address = {1'b0, desc.base} + prod_ff;

endmodule

/* rtl/multidim_array_address_calc_core.sv */
// multidim_array_address_calc_core: top level of the row-major array
// address calculator; depends on mdac_pkg, mdac_ram, mdac_seq, mdac_mac
// declare and bounds transactions are taken without raising busy; a
// subscript transaction holds busy through the multiply and accumulate
// states, a last subscript also through scale and output, from which the
// response strobe is registered; one shared multiplier sets the pace
// synchronous reset clears sequencer, offset, subscript position and
// response valid only; descriptor tables hold garbage until written
module multidim_array_address_calc_core
   import mdac_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    rsp_valid,
   output rsp_type rsp
);

   logic              accept;
   logic              index_start;
   cmd_type           cmd;
   logic [ID_W-1:0]   id;
   logic [SLOT_W-1:0] pos_ff;
   logic [SLOT_W-1:0] pos_in;
   logic [3:0]        id_ff;
   logic signed [15:0] sub_ff;
   logic              last_ff;
   logic              dim_wr;
   logic              desc_wr;
   dim_entry_type     dim_wdata;
   dim_entry_type     dim_rdata;
   desc_entry_type    desc_wdata;
   desc_entry_type    desc_rdata;
   ctrl_type          ctrl;
   logic [31:0]       address;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   assign accept = start & ~busy;
   assign cmd    = cmd_type'(req.command);
   assign id     = ID_W'(req.array_id);

   // command decode
   always_comb begin
      dim_wr      = 1'b0;
      desc_wr     = 1'b0;
      index_start = 1'b0;
      unique case (cmd)
         CMD_DECLARE: desc_wr     = accept;
         CMD_BOUNDS:  dim_wr      = accept;
         CMD_INDEX:   index_start = accept;
         default: begin
         end
      endcase
   end

   // table write data, extent kept mod 2^17
   always_comb begin
      dim_wdata.low    = req.lower_bound;
      dim_wdata.extent = 17'(req.upper_bound) - 17'(req.lower_bound) + 17'd1;
      desc_wdata.base  = req.base_address;
      desc_wdata.size  = req.element_size;
   end

   // dimension count is never checked, so it is not stored
   mdac_ram #(
      .WIDTH ($bits(dim_entry_type)),
      .DEPTH (DIM_DEPTH)
   ) u_dim_ram (
      .clock   (clock),
      .wr_en   (dim_wr),
      .wr_addr ({id, SLOT_W'(req.dim_slot)}),
      .wr_data (dim_wdata),
      .rd_en   (index_start),
      .rd_addr ({id, pos_ff}),
      .rd_data (dim_rdata)
   );

   mdac_ram #(
      .WIDTH ($bits(desc_entry_type)),
      .DEPTH (NUM_ARRAYS)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (desc_wr),
      .wr_addr (id),
      .wr_data (desc_wdata),
      .rd_en   (index_start),
      .rd_addr (id),
      .rd_data (desc_rdata)
   );

   // subscript transaction fields
   always_ff @(posedge clock) begin
      if (index_start) begin
         id_ff   <= req.array_id;
         sub_ff  <= req.subscript;
         last_ff <= req.last_subscript;
      end
   end

   mdac_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .index_start (index_start),
      .last        (last_ff),
      .busy        (busy),
      .ctrl        (ctrl)
   );

   mdac_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .dim       (dim_rdata),
      .desc      (desc_rdata),
      .subscript (sub_ff),
      .address   (address)
   );

   // subscript position, wraps with the slot width
   always_comb begin
      pos_in = pos_ff;
      priority if (ctrl.acc_clear) begin
         pos_in = '0;
      end else if (ctrl.acc_load) begin
         pos_in = pos_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= ctrl.rsp_load;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (ctrl.rsp_load) begin
         rsp_ff.address   <= address;
         rsp_ff.ref_array <= id_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* sim/multidim_array_address_calc_core_tb.sv */
// multidim_array_address_calc_core_tb: self-checking testbench for the row-major
// array address calculator; depends on mdac_pkg and multidim_array_address_calc_core
`timescale 1ns / 1ps

module multidim_array_address_calc_core_tb
   import mdac_pkg::*;
();

   // unused command code, must be ignored by the block
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int TARGET_ITEMS = 1150;
   localparam int QUIET_AFTER  = 1000;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_valid;
   rsp_type rsp;

   multidim_array_address_calc_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   // directed stimulus row, with an optional typed-in result
   typedef struct {
      req_type item;
      bit      fixed;
      rsp_type result;
   } step_row_type;

   // descriptor tables mirrored from accepted transactions
   logic [30:0] base_mem   [NUM_ARRAYS];
   logic [15:0] size_mem   [NUM_ARRAYS];
   logic [15:0] low_mem    [DIM_DEPTH];
   logic [16:0] extent_mem [DIM_DEPTH];
   bit          desc_known [NUM_ARRAYS];
   bit          dim_known  [DIM_DEPTH];
   logic [31:0]       offset_acc = '0;
   logic [SLOT_W-1:0] sub_pos    = '0;

   rsp_type      address_queue [$];
   step_row_type plan [$];
   int      error_count = 0;
   int      items_sent  = 0;
   int      cycle_count = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] widen(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   // transaction with every field random, the builders overwrite what matters
   function automatic req_type random_req();
      logic [127:0] noise_bits;
      noise_bits = {$urandom, $urandom, $urandom, $urandom};
      return noise_bits[$bits(req_type)-1:0];
   endfunction

   function automatic req_type mk_declare(input int id, input logic [30:0] base,
                                          input logic [15:0] size,
                                          input logic [3:0] dims);
      req_type r;
      r = random_req();
      r.command      = CMD_DECLARE;
      r.array_id     = id[3:0];
      r.base_address = base;
      r.element_size = size;
      r.dim_count    = dims;
      return r;
   endfunction

   function automatic req_type mk_bounds(input int id, input int slot,
                                         input logic [15:0] lo, input logic [15:0] hi);
      req_type r;
      r = random_req();
      r.command     = CMD_BOUNDS;
      r.array_id    = id[3:0];
      r.dim_slot    = slot[2:0];
      r.lower_bound = lo;
      r.upper_bound = hi;
      return r;
   endfunction

   function automatic req_type mk_index(input int id, input logic [15:0] sub,
                                        input bit is_last);
      req_type r;
      r = random_req();
      r.command        = CMD_INDEX;
      r.array_id       = id[3:0];
      r.subscript      = sub;
      r.last_subscript = is_last;
      return r;
   endfunction

   function automatic req_type rand_bounds(input int id, input int slot);
      logic [15:0] lo;
      logic [15:0] hi;
      lo = 16'($urandom);
      if ($urandom_range(0, 1) == 0)
         hi = lo + 16'($urandom_range(0, 15));
      else
         hi = 16'($urandom);
      return mk_bounds(id, slot, lo, hi);
   endfunction

   function automatic req_type rand_declare(input int id);
      return mk_declare(id, 31'($urandom), 16'($urandom), 4'($urandom));
   endfunction

   // expected address for one accepted transaction, updates the mirrored state
   function automatic void predict_address(input req_type r, input bit fixed,
                                           input rsp_type fixed_rsp);
      int          k;
      logic [31:0] span;
      logic [31:0] addr;
      case (r.command)
         CMD_DECLARE: begin
            base_mem[r.array_id]   = r.base_address;
            size_mem[r.array_id]   = r.element_size;
            desc_known[r.array_id] = 1'b1;
         end
         CMD_BOUNDS: begin
            k = int'(r.array_id) * MAX_DIMS + int'(r.dim_slot);
            span = widen(r.upper_bound) - widen(r.lower_bound) + 32'd1;
            low_mem[k]    = r.lower_bound;
            extent_mem[k] = span[16:0];
            dim_known[k]  = 1'b1;
         end
         CMD_INDEX: begin
            k = int'(r.array_id) * MAX_DIMS + int'(sub_pos);
            offset_acc = offset_acc * {15'd0, extent_mem[k]}
                         + (widen(r.subscript) - widen(low_mem[k]));
            sub_pos = sub_pos + SLOT_W'(1);
            if (r.last_subscript) begin
               addr = {1'b0, base_mem[r.array_id]} + {16'd0, size_mem[r.array_id]} * offset_acc;
               if (fixed)
                  address_queue = {address_queue, fixed_rsp};
               else
                  address_queue = {address_queue, rsp_type'({addr, r.array_id})};
               offset_acc = '0;
               sub_pos    = '0;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void add_row(input req_type r, input bit fixed = 1'b0,
                                   input rsp_type result = '0);
      step_row_type row;
      row.item   = r;
      row.fixed  = fixed;
      row.result = result;
      plan = {plan, row};
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   // drive one transaction and hold it until accepted, then maybe go idle
   task automatic send(input req_type r, input bit fixed = 1'b0,
                       input rsp_type fixed_rsp = '0);
      req   <= r;
      start <= 1'b1;
      do begin
         @(posedge clock);
      end while (busy);
      predict_address(r, fixed, fixed_rsp);
      if (r.command != CMD_UNUSED)
         items_sent++;
      if (items_sent < QUIET_AFTER && $urandom_range(0, 7) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // make sure the next subscript only touches written table entries
   task automatic prepare(input int id, input bit is_last);
      int k;
      k = id * MAX_DIMS + int'(sub_pos);
      if (!dim_known[k] || $urandom_range(0, 19) == 0)
         send(rand_bounds(id, int'(sub_pos)));
      if (is_last && (!desc_known[id] || $urandom_range(0, 19) == 0))
         send(rand_declare(id));
   endtask

   function automatic logic [15:0] pick_subscript(input int id);
      int k;
      k = id * MAX_DIMS + int'(sub_pos);
      if ($urandom_range(0, 1) == 0)
         return low_mem[k] + 16'($urandom_range(0, 7));
      return 16'($urandom);
   endfunction

   // one well-formed reference, sometimes with mixed ids or too many subscripts
   task automatic run_reference();
      int n;
      int ref_id;
      int id;
      bit is_last;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 8);
      ref_id = $urandom_range(0, NUM_ARRAYS - 1);
      if ($urandom_range(0, 4) == 0)
         send(rand_declare(ref_id));
      for (int i = 0; i < n; i++) begin
         is_last = (i == n - 1);
         id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NUM_ARRAYS - 1) : ref_id;
         prepare(id, is_last);
         send(mk_index(id, pick_subscript(id), is_last));
      end
   endtask

   // stray transactions between references
   task automatic send_noise();
      req_type r;
      int      id;
      bit      is_last;
      id = $urandom_range(0, NUM_ARRAYS - 1);
      case ($urandom_range(0, 3))
         0: begin
            r = random_req();
            r.command = CMD_UNUSED;
            send(r);
         end
         1: send(rand_declare(id));
         2: send(rand_bounds(id, $urandom_range(0, MAX_DIMS - 1)));
         default: begin
            is_last = 1'($urandom_range(0, 1));
            prepare(id, is_last);
            send(mk_index(id, pick_subscript(id), is_last));
         end
      endcase
   endtask

   // response checker
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (address_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected response address %08h array %0d",
                                      rsp.address, rsp.ref_array));
         end else begin
            want = address_queue.pop_front();
            if (rsp.address !== want.address)
               report_mismatch($sformatf("address %08h, expected %08h",
                                         rsp.address, want.address));
            if (rsp.ref_array !== want.ref_array)
               report_mismatch($sformatf("ref_array %0d, expected %0d",
                                         rsp.ref_array, want.ref_array));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("multidim_array_address_calc_core_tb: errors");
         $finish;
      end
   end

   // stimulus
   initial begin
      reset = 1'b1;
      start = 1'b0;
      req   = '0;

      // extremes of a one-dimensional array
      add_row(mk_declare(0, 31'h7FFF_FFFF, 16'hFFFF, 4'hF));
      add_row(mk_bounds(0, 0, 16'sh8000, 16'sh7FFF));
      add_row(mk_index(0, 16'sh8000, 1'b1), 1'b1, rsp_type'({32'h7FFF_FFFF, 4'd0}));
      add_row(mk_index(0, 16'sh7FFF, 1'b1), 1'b1, rsp_type'({32'h7FFE_0000, 4'd0}));
      // small two-dimensional array, plus a slot with upper below lower
      add_row(mk_declare(15, 31'd0, 16'd1, 4'd0));
      add_row(mk_bounds(15, 0, 16'd1, 16'd3));
      add_row(mk_bounds(15, 1, 16'd0, 16'd4));
      add_row(mk_bounds(15, 7, 16'd5, 16'd2));
      add_row(mk_index(15, 16'd2, 1'b0));
      add_row(mk_index(15, 16'd3, 1'b1), 1'b1, rsp_type'({32'd8, 4'd15}));
      // ignored command
      add_row('{command: CMD_UNUSED, default: '1});
      // mixed ids within one reference
      add_row(mk_bounds(0, 1, 16'd0, 16'd0));
      add_row(mk_index(15, 16'd3, 1'b0));
      add_row(mk_index(0, 16'd7, 1'b1));
      // extent wrapping through the 17-bit field
      add_row(mk_declare(7, 31'h0001_2345, 16'h0100, 4'd1));
      add_row(mk_bounds(7, 0, 16'sh7FFF, 16'sh8000));
      add_row(mk_index(7, 16'shFFFF, 1'b1));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         send(plan[i].item, plan[i].fixed, plan[i].result);

      // random references and noise
      while (items_sent < TARGET_ITEMS) begin
         if ($urandom_range(0, 99) < 75)
            run_reference();
         else
            send_noise();
      end
      start <= 1'b0;

      // drain
      while (address_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("multidim_array_address_calc_core_tb: clean");
      else
         $display("multidim_array_address_calc_core_tb: errors");
      $finish;
   end

endmodule

/* multidim_array_address_calc_core.f */
rtl/mdac_pkg.sv
rtl/mdac_ram.sv
rtl/mdac_seq.sv
rtl/mdac_mac.sv
rtl/multidim_array_address_calc_core.sv
sim/multidim_array_address_calc_core_tb.sv
